// ===== hdl/twt_pkg.sv =====
// ----------------------------------------------------------------------------
// twt_pkg
// Shared status codes, serial constants and controller/datapath bundles
// for the timing wheel timer.
// ----------------------------------------------------------------------------
package twt_pkg;

    localparam logic [1:0] ST_ADDED    = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_EXPIRED  = 2'd2;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [31:0] SERIAL_FIRST = 32'h0000_0001;
    localparam logic [31:0] SERIAL_WRAP  = 32'hFFFF_FFFE;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the input word
        logic tick_adv;  // advance the wheel position
        logic clr;       // clear one slot head
        logic add_a;     // slot, node, reject flag, reciprocal product
        logic add_b;     // interval position/level, slot read
        logic add_c;     // link the node, emit the add result
        logic rej;       // emit a rejection
        logic tick_rd;   // read the slot reached by the tick
        logic node_rd;   // read the first node of the slot
        logic expire;    // emit one expiry, walk to the next node
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic reject;
        logic head_empty;
        logic is_last;
        logic out_free;
    } t_stat;

endpackage

// ===== hdl/timing_wheel_timer.sv =====
// ----------------------------------------------------------------------------
// timing_wheel_timer
// Hashed timing wheel with per-slot timer lists in a fixed node pool.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot head memory, one slot per cycle,
// through all WHEEL_LEN*WHEEL_LEVELS slots before it takes its first word.
// One word is in flight at a time. An add registers the reciprocal product,
// then splits the interval into position and level while the slot memory is
// read, then links the node and registers the result; a rejection skips the
// slot read. A tick advances the wheel, reads its slot, then delivers one
// expiry per cycle while the output side keeps up, walking the slot list
// through the node memories; an empty slot returns to idle without a result.
module timing_wheel_timer #(
    parameter int WHEEL_LEN    = 64,
    parameter int WHEEL_LEVELS = 4,
    parameter int NODE_POOL    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [15:0] i_interval,
    input  logic [63:0] i_payload,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [63:0] o_timer_id,
    output logic [63:0] o_expired_payload,
    output logic [5:0]  o_live_count,
    output logic        o_last
);
    import twt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    twt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    twt_dp #(
        .WHEEL_LEN    (WHEEL_LEN),
        .WHEEL_LEVELS (WHEEL_LEVELS),
        .NODE_POOL    (NODE_POOL)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_interval        (i_interval),
        .i_payload         (i_payload),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_timer_id        (o_timer_id),
        .o_expired_payload (o_expired_payload),
        .o_live_count      (o_live_count),
        .o_last            (o_last)
    );

endmodule

// ===== hdl/twt_ctrl.sv =====
// ----------------------------------------------------------------------------
// twt_ctrl
// Sequencer for the timing wheel: clear pass, add steps and the slot walk.
// ----------------------------------------------------------------------------
module twt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_req_type,
    input  twt_pkg::t_stat i_stat,
    output logic          o_in_ready,
    output twt_pkg::t_cmd  o_cmd
);
    import twt_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_ADD0, S_ADD1, S_ADD2, S_TICK1, S_TICK2, S_TICK3
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;
    logic   accept;

    assign accept     = i_in_valid && r_ready;
    assign o_in_ready = r_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    if (i_req_type == REQ_TICK) begin
                        o_cmd.tick_adv = 1'b1;
                        n_state = S_TICK1;
                    end else begin
                        n_state = S_ADD0;
                    end
                end
            end
            S_ADD0: begin
                o_cmd.add_a = 1'b1;
                n_state = S_ADD1;
            end
            S_ADD1: begin
                if (i_stat.reject) begin
                    if (i_stat.out_free) begin
                        o_cmd.rej = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.add_b = 1'b1;
                    n_state = S_ADD2;
                end
            end
            S_ADD2: begin
                if (i_stat.out_free) begin
                    o_cmd.add_c = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_TICK1: begin
                o_cmd.tick_rd = 1'b1;
                n_state = S_TICK2;
            end
            S_TICK2: begin
                if (i_stat.head_empty) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.node_rd = 1'b1;
                    n_state = S_TICK3;
                end
            end
            S_TICK3: begin
                if (i_stat.out_free) begin
                    o_cmd.expire = 1'b1;
                    if (i_stat.is_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

endmodule

// ===== hdl/twt_dp.sv =====
// ----------------------------------------------------------------------------
// twt_dp
// Datapath: wheel position, slot lists, node pool and the result register.
// ----------------------------------------------------------------------------
module twt_dp #(
    parameter int WHEEL_LEN    = 64,
    parameter int WHEEL_LEVELS = 4,
    parameter int NODE_POOL    = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  twt_pkg::t_cmd  i_cmd,
    output twt_pkg::t_stat o_stat,
    input  logic [15:0]   i_interval,
    input  logic [63:0]   i_payload,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [1:0]    o_status,
    output logic [63:0]   o_timer_id,
    output logic [63:0]   o_expired_payload,
    output logic [5:0]    o_live_count,
    output logic          o_last
);
    import twt_pkg::*;

    localparam int SPAN = WHEEL_LEN * WHEEL_LEVELS;
    localparam int SW   = $clog2(SPAN);
    localparam int PW   = $clog2(WHEEL_LEN);
    localparam int LVW  = (WHEEL_LEVELS > 1) ? $clog2(WHEEL_LEVELS) : 1;
    localparam int NW   = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
    localparam int CW   = $clog2(NODE_POOL + 1);
    localparam int SUMW = ((SW > 16) ? SW : 16) + 1;
    localparam logic [31:0] RECIP =
        32'(((64'd1 << 32) + 64'(WHEEL_LEN) - 64'd1) / 64'(WHEEL_LEN));

    // wheel position
    logic [SW-1:0]  r_tick_slot;
    logic [PW-1:0]  r_tick_pos;
    logic [LVW-1:0] r_tick_lvl;
    logic [31:0]    r_serial;
    logic [CW-1:0]  r_pending;
    logic [NODE_POOL-1:0] r_free;
    logic [SW-1:0]  r_clr;

    // request and add pipeline
    logic [15:0]    r_interval;
    logic [63:0]    r_payload;
    logic [SW-1:0]  r_slot;
    logic [NW-1:0]  r_node;
    logic           r_reject;
    logic [47:0]    r_prod;
    logic [PW-1:0]  r_ipos;
    logic [LVW-1:0] r_ilvl;
    logic [NW-1:0]  r_cur;

    // memories
    logic [NW:0]    r_head_mem [SPAN];
    logic [NW-1:0]  r_tail_mem [SPAN];
    logic [31:0]    r_nser_mem [NODE_POOL];
    logic [63:0]    r_nval_mem [NODE_POOL];
    logic [NW-1:0]  r_link_mem [NODE_POOL];
    logic [NW:0]    r_head_q;
    logic [NW-1:0]  r_tail_q;
    logic [31:0]    r_nser_q;
    logic [63:0]    r_nval_q;
    logic [NW-1:0]  r_link_q;

    // result register
    logic           r_out_valid;
    logic [1:0]     r_status;
    logic [63:0]    r_timer_id;
    logic [63:0]    r_exp_pl;
    logic [5:0]     r_live;
    logic           r_last;

    logic           out_free;
    logic           any_free;
    logic [NW-1:0]  first_free;
    logic [SUMW-1:0] slot_sum;
    logic [SW-1:0]  slot_new;
    logic [15:0]    quot;
    logic [31:0]    ipos_full;
    logic [PW:0]    psum;
    logic           pcarry;
    logic [PW-1:0]  tgt_pos;
    logic [LVW:0]   lsum;
    logic [LVW-1:0] tgt_lvl;
    logic [31:0]    serial_inc;
    logic           expire_last;
    logic           head_we;
    logic [SW-1:0]  head_wa;
    logic [NW:0]    head_wd;
    logic [SW-1:0]  slot_ra;
    logic           node_re;
    logic [NW-1:0]  node_ra;
    logic           link_we;
    logic [NW-1:0]  link_wa;
    logic [NW-1:0]  link_wd;

    assign out_free    = !r_out_valid || i_out_ready;
    assign expire_last = (r_cur == r_tail_q);

    always_comb begin
        any_free   = 1'b0;
        first_free = '0;
        for (int i = NODE_POOL - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                any_free   = 1'b1;
                first_free = NW'(i);
            end
        end
    end

    assign slot_sum = SUMW'(r_tick_slot) + SUMW'(r_interval);
    assign slot_new = (slot_sum >= SUMW'(SPAN)) ? SW'(slot_sum - SUMW'(SPAN)) : SW'(slot_sum);

    // interval split into position and level by reciprocal multiply
    assign quot      = r_prod[47:32];
    assign ipos_full = 32'(r_interval) - 32'(quot) * 32'(WHEEL_LEN);

    assign psum    = (PW+1)'(r_tick_pos) + (PW+1)'(r_ipos);
    assign pcarry  = (psum >= (PW+1)'(WHEEL_LEN));
    assign tgt_pos = pcarry ? PW'(psum - (PW+1)'(WHEEL_LEN)) : PW'(psum);
    assign lsum    = (LVW+1)'(r_tick_lvl) + (LVW+1)'(r_ilvl) + (LVW+1)'(pcarry);
    assign tgt_lvl = (lsum >= (LVW+1)'(WHEEL_LEVELS)) ?
                     LVW'(lsum - (LVW+1)'(WHEEL_LEVELS)) : LVW'(lsum);

    assign serial_inc = r_serial + 32'd1;

    // memory port muxes
    always_comb begin
        head_we = 1'b0;
        head_wa = r_clr;
        head_wd = {1'b1, NW'(0)};
        if (i_cmd.clr) begin
            head_we = 1'b1;
        end else if (i_cmd.add_c && r_head_q[NW]) begin
            head_we = 1'b1;
            head_wa = r_slot;
            head_wd = {1'b0, r_node};
        end else if (i_cmd.expire && expire_last) begin
            head_we = 1'b1;
            head_wa = r_tick_slot;
        end
    end

    assign slot_ra = i_cmd.add_b ? r_slot : r_tick_slot;
    assign node_re = i_cmd.node_rd || (i_cmd.expire && !expire_last);
    assign node_ra = i_cmd.node_rd ? r_head_q[NW-1:0] : r_link_q;
    assign link_we = i_cmd.add_b || (i_cmd.add_c && !r_head_q[NW]);
    assign link_wa = i_cmd.add_b ? r_node : r_tail_q;
    assign link_wd = i_cmd.add_b ? NW'(0) : r_node;

    always_ff @(posedge i_clk) begin
        if (head_we) r_head_mem[head_wa] <= head_wd;
        if (i_cmd.add_b || i_cmd.tick_rd) r_head_q <= r_head_mem[slot_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_c) r_tail_mem[r_slot] <= r_node;
        if (i_cmd.add_b || i_cmd.tick_rd) r_tail_q <= r_tail_mem[slot_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_c) r_nser_mem[r_node] <= r_serial;
        if (node_re) r_nser_q <= r_nser_mem[node_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_c) r_nval_mem[r_node] <= r_payload;
        if (node_re) r_nval_q <= r_nval_mem[node_ra];
    end

    always_ff @(posedge i_clk) begin
        if (link_we) r_link_mem[link_wa] <= link_wd;
        if (node_re) r_link_q <= r_link_mem[node_ra];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_interval <= i_interval;
            r_payload  <= i_payload;
        end
        if (i_cmd.add_a) begin
            r_slot   <= slot_new;
            r_node   <= first_free;
            r_prod   <= 48'(r_interval) * 48'(RECIP);
            r_reject <= (r_interval == 16'd0) || (32'(r_interval) >= 32'(SPAN)) || !any_free;
        end
        if (i_cmd.add_b) begin
            r_ipos <= PW'(ipos_full);
            r_ilvl <= LVW'(quot);
        end
        if (i_cmd.node_rd) r_cur <= r_head_q[NW-1:0];
        else if (node_re) r_cur <= r_link_q;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_slot <= '0;
            r_tick_pos  <= '0;
            r_tick_lvl  <= '0;
            r_serial    <= SERIAL_FIRST;
            r_pending   <= '0;
            r_free      <= '1;
            r_clr       <= '0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + SW'(1);
            if (i_cmd.tick_adv) begin
                r_tick_slot <= (r_tick_slot == SW'(SPAN - 1)) ? '0 : r_tick_slot + SW'(1);
                if (r_tick_pos == PW'(WHEEL_LEN - 1)) begin
                    r_tick_pos <= '0;
                    r_tick_lvl <= (r_tick_lvl == LVW'(WHEEL_LEVELS - 1)) ?
                                  '0 : r_tick_lvl + LVW'(1);
                end else begin
                    r_tick_pos <= r_tick_pos + PW'(1);
                end
            end
            if (i_cmd.add_c) begin
                r_serial       <= (serial_inc == SERIAL_WRAP) ? SERIAL_FIRST : serial_inc;
                r_pending      <= r_pending + CW'(1);
                r_free[r_node] <= 1'b0;
            end
            if (i_cmd.expire) begin
                r_pending     <= r_pending - CW'(1);
                r_free[r_cur] <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.rej || i_cmd.add_c || i_cmd.expire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.rej) begin
            r_status   <= ST_REJECTED;
            r_timer_id <= '0;
            r_exp_pl   <= '0;
            r_live     <= 6'(r_pending);
            r_last     <= 1'b1;
        end else if (i_cmd.add_c) begin
            r_status   <= ST_ADDED;
            r_timer_id <= {r_serial, 16'(tgt_pos), 16'(tgt_lvl)};
            r_exp_pl   <= '0;
            r_live     <= 6'(r_pending + CW'(1));
            r_last     <= 1'b1;
        end else if (i_cmd.expire) begin
            r_status   <= ST_EXPIRED;
            r_timer_id <= {r_nser_q, 16'(r_tick_pos), 16'(r_tick_lvl)};
            r_exp_pl   <= r_nval_q;
            r_live     <= 6'(r_pending - CW'(1));
            r_last     <= expire_last;
        end
    end

    assign o_stat.clr_done   = (r_clr == SW'(SPAN - 1));
    assign o_stat.reject     = r_reject;
    assign o_stat.head_empty = r_head_q[NW];
    assign o_stat.is_last    = expire_last;
    assign o_stat.out_free   = out_free;

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_timer_id        = r_timer_id;
    assign o_expired_payload = r_exp_pl;
    assign o_live_count      = r_live;
    assign o_last            = r_last;

endmodule

// ===== hdl/twt_checker.sv =====
// ----------------------------------------------------------------------------
// twt_checker
// Port-level checks on the timing wheel result channel.
// ----------------------------------------------------------------------------
module twt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [63:0] o_timer_id,
    input logic [63:0] o_expired_payload,
    input logic        o_last
);
    import twt_pkg::*;

    // hold a stalled word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_timer_id))
        else $error("result word dropped or changed while stalled");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_ADDED || o_status == ST_REJECTED ||
                         o_status == ST_EXPIRED))
        else $error("undefined status code");

    // add results are single words with no payload
    a_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_EXPIRED |-> o_last && o_expired_payload == 64'd0)
        else $error("add result not final or carries payload");

    a_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_REJECTED |-> o_timer_id == 64'd0)
        else $error("rejected add carries an id");

endmodule

bind timing_wheel_timer twt_checker u_twt_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_status          (o_status),
    .o_timer_id        (o_timer_id),
    .o_expired_payload (o_expired_payload),
    .o_last            (o_last)
);

// ===== tb/tb_timing_wheel_timer.sv =====
// ----------------------------------------------------------------------------
// tb_timing_wheel_timer
// Self-checking bench for the timing wheel timer: a queue-fed driver sends
// add and tick words with random idle gaps, a behavioral wheel predicts every
// result word, and a monitor compares each accepted result in order.
// ----------------------------------------------------------------------------
module tb_timing_wheel_timer;
    timeunit 1ns;
    timeprecision 1ps;
    import twt_pkg::*;

    localparam int WLEN  = 64;
    localparam int WLVL  = 4;
    localparam int POOL  = 32;
    localparam int SPAN  = WLEN * WLVL;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic        req;
        logic [15:0] interval;
        logic [63:0] payload;
    } t_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] timer_id;
        logic [63:0] payload;
        logic [5:0]  live;
        logic        last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_req_type = 1'b0;
    logic [15:0] i_interval = '0;
    logic [63:0] i_payload = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [63:0] o_timer_id;
    logic [63:0] o_expired_payload;
    logic [5:0]  o_live_count;
    logic        o_last;

    timing_wheel_timer #(.WHEEL_LEN(WLEN), .WHEEL_LEVELS(WLVL), .NODE_POOL(POOL)) DUT (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_req_type, .i_interval,
        .i_payload, .o_out_valid, .i_out_ready, .o_status, .o_timer_id,
        .o_expired_payload, .o_live_count, .o_last
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // wheel state of the predictor
    logic [7:0]  wheel_pos;
    logic [31:0] serial_next;
    logic [5:0]  live_timers;
    int          head_of [SPAN];
    int          tail_of [SPAN];
    logic [31:0] node_ser [POOL];
    logic [63:0] node_val [POOL];
    int          node_nxt [POOL];
    bit          node_busy [POOL];

    t_word   pending_words [$];
    t_result expected_results [$];
    int      mismatches = 0;
    int      cycles = 0;
    bit      stim_done = 0;
    bit      no_idle = 0;

    task automatic queue_word(t_word w);
        pending_words = {pending_words, w};
    endtask

    task automatic expect_word(t_result r);
        expected_results = {expected_results, r};
    endtask

    function automatic logic [63:0] timer_id_of(logic [31:0] ser, int slot);
        return {ser, 16'(slot % WLEN), 16'(slot / WLEN)};
    endfunction

    task automatic wheel_clear();
        wheel_pos = '0;
        serial_next = SERIAL_FIRST;
        live_timers = '0;
        for (int s = 0; s < SPAN; s++) head_of[s] = -1;
        for (int n = 0; n < POOL; n++) node_busy[n] = 0;
    endtask

    task automatic wheel_predict(t_word w);
        int node;
        int slot;
        int cur;
        node = -1;
        if (w.req == REQ_ADD) begin
            for (int n = POOL - 1; n >= 0; n--) if (!node_busy[n]) node = n;
            if (w.interval == 0 || w.interval >= SPAN || node < 0) begin
                expect_word({ST_REJECTED, 64'd0, 64'd0, live_timers, 1'b1});
                return;
            end
            slot = (int'(wheel_pos) + int'(w.interval)) % SPAN;
            node_busy[node] = 1;
            node_ser[node] = serial_next;
            node_val[node] = w.payload;
            node_nxt[node] = -1;
            if (head_of[slot] < 0) head_of[slot] = node;
            else node_nxt[tail_of[slot]] = node;
            tail_of[slot] = node;
            live_timers++;
            expect_word({ST_ADDED, timer_id_of(serial_next, slot), 64'd0,
                         live_timers, 1'b1});
            serial_next++;
            if (serial_next == SERIAL_WRAP) serial_next = SERIAL_FIRST;
        end else begin
            wheel_pos = 8'((int'(wheel_pos) + 1) % SPAN);
            slot = wheel_pos;
            cur = head_of[slot];
            while (cur >= 0) begin
                live_timers--;
                expect_word({ST_EXPIRED, timer_id_of(node_ser[cur], slot),
                             node_val[cur], live_timers,
                             1'(cur == tail_of[slot])});
                node_busy[cur] = 0;
                cur = (cur == tail_of[slot]) ? -1 : node_nxt[cur];
            end
            head_of[slot] = -1;
        end
    endtask

    function automatic t_word add_word(int iv);
        return {REQ_ADD, 16'(iv), {$urandom, $urandom}};
    endfunction

    function automatic t_word tick_word();
        return {REQ_TICK, 16'($urandom), {$urandom, $urandom}};
    endfunction

    // driver: advance on acceptance, idle at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) void'(pending_words.pop_front());
            if (pending_words.size() > 0 &&
                (no_idle || $urandom_range(99) >= 34)) begin
                t_word w;
                w = pending_words[0];
                i_in_valid <= 1'b1;
                i_req_type <= w.req;
                i_interval <= w.interval;
                i_payload  <= w.payload;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // predict on acceptance, check result words in order
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                wheel_predict({i_req_type, i_interval, i_payload});
            if (o_out_valid && i_out_ready) begin
                t_result got;
                got = {o_status, o_timer_id, o_expired_payload, o_live_count, o_last};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result word %h", got);
                end else begin
                    t_result exp_r;
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp st=%0d id=%h pl=%h live=%0d last=%0b",
                                      " | got st=%0d id=%h pl=%h live=%0d last=%0b"},
                                     exp_r.status, exp_r.timer_id, exp_r.payload, exp_r.live,
                                     exp_r.last, got.status, got.timer_id, got.payload,
                                     got.live, got.last);
                    end
                end
            end
            i_out_ready <= no_idle || $urandom_range(99) >= 34;
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        wheel_clear();
        // directed: extremes, rejections, same-slot order, pool full
        queue_word(add_word(0));
        queue_word(add_word(SPAN));
        queue_word(add_word(16'hFFFF));
        queue_word({REQ_ADD, 16'd1, 64'hFFFF_FFFF_FFFF_FFFF});
        queue_word({REQ_ADD, 16'd1, 64'h0});
        queue_word(add_word(SPAN - 1));
        queue_word(add_word(2));
        queue_word(tick_word());
        queue_word(tick_word());
        queue_word({REQ_TICK, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF});
        for (int k = 0; k < POOL + 1; k++) queue_word(add_word(3 + k % 2));
        for (int k = 0; k < 3; k++) queue_word(tick_word());
        // random: bursts of short adds and ticks so slots fill and drain
        for (int k = 0; k < 200; k++) begin
            int r;
            r = $urandom_range(99);
            if (r < 45) queue_word(tick_word());
            else if (r < 85) queue_word(add_word($urandom_range(1, 12)));
            else if (r < 95) queue_word(add_word($urandom_range(1, SPAN - 1)));
            else queue_word(add_word($urandom_range(0, 16'hFFFF)));
        end
        for (int k = 0; k < 64; k++) queue_word(tick_word());
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            begin
                repeat (1500) @(posedge i_clk);
                no_idle = 1;
                repeat (800) @(posedge i_clk);
                no_idle = 0;
            end
        join_none
        wait (pending_words.size() == 0 && !i_in_valid);
        wait (expected_results.size() == 0);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/twt_pkg.sv
hdl/twt_ctrl.sv
hdl/twt_dp.sv
hdl/timing_wheel_timer.sv
hdl/twt_checker.sv
tb/tb_timing_wheel_timer.sv
